>>> rtl/core/jsu_pkg.sv
// Shared types and constants of the JSON string unescaper.
// Used by the front, the burst queue, the back and the top level.
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

    // Largest number of result bytes that one raw byte can cause.
    localparam int unsigned BURST_MAX = 7;
    localparam int unsigned BURST_CW  = $clog2(BURST_MAX + 1);

    // Burst queue depth (a power of two, so the pointers wrap by themselves).
    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int unsigned Q_CW    = $clog2(Q_DEPTH + 1);

    // One burst: the bytes caused by one raw byte. A count of zero with
    // last set is the empty end marker.
    typedef struct packed {
        logic                           last;
        logic [BURST_CW-1:0]            count;
        logic [BURST_MAX-1:0][7:0]      bytes;
    } t_burst;

endpackage

`default_nettype wire

>>> rtl/core/json_string_unescape_utf8_top.sv
// Top level of the JSON string unescaper (raw string body in, UTF-8 out).
// Instantiates jsu_front, jsu_queue and jsu_back; depends on jsu_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Takes one raw byte of a JSON string body per accepted input word, escapes
// still in place, and returns the unescaped text as UTF-8, one byte per output
// word. Simple escapes become their characters, unknown escapes give the
// escaped character, \uXXXX becomes 1 to 3 bytes and a high/low surrogate
// pair becomes 4 bytes; lone surrogates come out as 3 bytes and bad or short
// \u digit runs come out literally. The word caused by the last raw byte
// carries o_end_of_string; a last byte that produces nothing gives an empty
// marker word (o_byte_valid low). Rate: the input takes one byte per cycle
// whenever the two-entry burst queue has room; the output gives one byte per
// cycle while i_ready is high, so a raw byte that expands to k result bytes
// (k is at most 7) fills k output words and the queue absorbs such bursts.
// With the queue and the output register empty, the first result of a byte
// goes through the burst queue and then the output register.
// The reset is synchronous and active low and clears all control state.
module json_string_unescape_utf8_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // raw byte channel
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_raw_byte,
    input  logic       i_is_last,
    // decoded byte channel
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic       o_end_of_string
);

    // Burst word from the front and the head of the queue seen by the back.
    jsu_pkg::t_burst w_burst;
    jsu_pkg::t_burst w_head;
    logic            w_push;
    logic            w_pop;
    logic            w_full;
    logic            w_head_valid;

    // Front: decode the escape grammar and build one burst per raw byte.
    jsu_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_raw_byte (i_raw_byte),
        .i_is_last  (i_is_last),
        .i_q_full   (w_full),
        .o_ready    (o_ready),
        .o_push     (w_push),
        .o_burst    (w_burst)
    );

    // Queue: hold bursts so the front keeps going while the back drains.
    jsu_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_burst      (w_burst),
        .i_pop        (w_pop),
        .o_full       (w_full),
        .o_head_valid (w_head_valid),
        .o_head       (w_head)
    );

    // Back: advance through the head burst, one word per cycle unless stalled.
    jsu_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head_valid    (w_head_valid),
        .i_head          (w_head),
        .o_pop           (w_pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_out_byte      (o_out_byte),
        .o_byte_valid    (o_byte_valid),
        .o_end_of_string (o_end_of_string)
    );

`ifndef ASSERT_OFF
    // An empty marker word only ever closes a string.
    a_marker_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_byte_valid |-> o_end_of_string)
        else $error("empty marker word without end of string");

    // The front never pushes into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("burst pushed into full queue");

    // The back pops only a burst that is there.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_head_valid)
        else $error("burst popped from empty queue");

    // A queued burst carries bytes or closes a string.
    a_burst_useful: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (w_burst.count != '0) || w_burst.last)
        else $error("empty burst pushed in mid string");
`endif

endmodule

`default_nettype wire

>>> rtl/core/jsu_front.sv
// Front of the JSON string unescaper: escape state machine and UTF-8 encode.
// Turns each accepted raw byte into one burst word; depends on jsu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jsu_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [7:0]       i_raw_byte,
    input  logic             i_is_last,
    input  logic             i_q_full,
    output logic             o_ready,
    output logic             o_push,
    output jsu_pkg::t_burst  o_burst
);

    localparam logic [2:0] PH_PLAIN   = 3'd0;
    localparam logic [2:0] PH_ESC     = 3'd1;
    localparam logic [2:0] PH_HEX1    = 3'd2;
    localparam logic [2:0] PH_WAIT_BS = 3'd3;
    localparam logic [2:0] PH_WAIT_U  = 3'd4;
    localparam logic [2:0] PH_HEX2    = 3'd5;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LC_B   = 8'h62;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_LC_N   = 8'h6E;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_LC_T   = 8'h74;
    localparam logic [7:0] CH_LC_U   = 8'h75;

    localparam logic [1:0] LAST_DIGIT = 2'd3;

    typedef struct packed {
        logic [2:0]      cnt;
        logic [7:0][7:0] data;
    } t_obuf;

    function automatic t_obuf f_put_byte(t_obuf o, logic [7:0] b);
        t_obuf r;
        r = o;
        r.data[r.cnt] = b;
        r.cnt = r.cnt + 3'd1;
        return r;
    endfunction

    function automatic t_obuf f_put_code(t_obuf o, logic [20:0] cp);
        t_obuf           r;
        logic [3:0][7:0] enc;
        logic [2:0]      len;
        r   = o;
        enc = '0;
        if (cp <= 21'h7F) begin
            enc[0] = cp[7:0];
            len = 3'd1;
        end else if (cp <= 21'h7FF) begin
            enc[0] = {3'b110, cp[10:6]};
            enc[1] = {2'b10, cp[5:0]};
            len = 3'd2;
        end else if (cp <= 21'hFFFF) begin
            enc[0] = {4'b1110, cp[15:12]};
            enc[1] = {2'b10, cp[11:6]};
            enc[2] = {2'b10, cp[5:0]};
            len = 3'd3;
        end else begin
            enc[0] = {5'b11110, cp[20:18]};
            enc[1] = {2'b10, cp[17:12]};
            enc[2] = {2'b10, cp[11:6]};
            enc[3] = {2'b10, cp[5:0]};
            len = 3'd4;
        end
        for (int j = 0; j < 4; j++) begin
            if (3'(j) < len) begin
                r = f_put_byte(r, enc[j]);
            end
        end
        return r;
    endfunction

    // Held high surrogate goes out as a plain 3-byte sequence.
    function automatic t_obuf f_put_high(t_obuf o, logic [9:0] hb);
        return f_put_code(o, {5'd0, 6'b110110, hb});
    endfunction

    function automatic t_obuf f_put_held(t_obuf o, logic [1:0] seen,
                                         logic [2:0][7:0] held);
        t_obuf r;
        r = o;
        for (int k = 0; k < 3; k++) begin
            if (2'(k) < seen) begin
                r = f_put_byte(r, held[k]);
            end
        end
        return r;
    endfunction

    function automatic logic [4:0] f_hex(logic [7:0] b);
        logic [4:0] r;
        r = '0;
        if (b inside {[8'h30:8'h39]}) begin
            r = {1'b1, b[3:0]};
        end else if (b inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
            r = {1'b1, b[3:0] + 4'd9};
        end
        return r;
    endfunction

    logic [2:0]       r_phase, n_phase;
    logic [15:0]      r_acc, n_acc;
    logic [1:0]       r_seen, n_seen;
    logic [2:0][7:0]  r_held, n_held;
    logic [9:0]       r_hb, n_hb;

    logic             w_accept;
    t_obuf            v_ob;
    logic             v_done;
    logic [4:0]       v_hex;
    logic             v_full4;
    logic [20:0]      v_pair;

    assign o_ready  = !i_q_full;
    assign w_accept = i_valid && o_ready;

    always_comb begin
        n_phase = r_phase;
        n_acc   = r_acc;
        n_seen  = r_seen;
        n_held  = r_held;
        n_hb    = r_hb;
        v_ob    = '0;
        v_done  = 1'b0;
        v_hex   = f_hex(i_raw_byte);
        v_full4 = 1'b0;
        v_pair  = '0;

        // Revisit the same byte when a state gives up on it (at most twice).
        for (int it = 0; it < 3; it++) begin
            if (!v_done) begin
                v_done = 1'b1;
                case (n_phase)
                    PH_PLAIN: begin
                        if (i_raw_byte == CH_BSLASH) begin
                            n_phase = PH_ESC;
                        end else begin
                            v_ob = f_put_byte(v_ob, i_raw_byte);
                        end
                    end
                    PH_ESC: begin
                        n_phase = PH_PLAIN;
                        case (i_raw_byte)
                            CH_LC_B: v_ob = f_put_byte(v_ob, 8'h08);
                            CH_LC_F: v_ob = f_put_byte(v_ob, 8'h0C);
                            CH_LC_N: v_ob = f_put_byte(v_ob, 8'h0A);
                            CH_LC_R: v_ob = f_put_byte(v_ob, 8'h0D);
                            CH_LC_T: v_ob = f_put_byte(v_ob, 8'h09);
                            CH_LC_U: begin
                                n_phase = PH_HEX1;
                                n_acc   = '0;
                                n_seen  = '0;
                            end
                            default: v_ob = f_put_byte(v_ob, i_raw_byte);
                        endcase
                    end
                    PH_HEX1, PH_HEX2: begin
                        if (!v_hex[4]) begin
                            if (n_phase == PH_HEX2) begin
                                v_ob = f_put_high(v_ob, n_hb);
                            end
                            v_ob    = f_put_held(v_ob, n_seen, n_held);
                            n_seen  = '0;
                            n_phase = PH_PLAIN;
                            v_done  = 1'b0;
                        end else begin
                            n_acc = {n_acc[11:0], v_hex[3:0]};
                            v_full4 = (n_seen == LAST_DIGIT);
                            if (v_full4) begin
                                n_seen = '0;
                            end else begin
                                n_held[n_seen] = i_raw_byte;
                                n_seen = n_seen + 2'd1;
                            end
                            if (v_full4) begin
                                if ((n_phase == PH_HEX2) &&
                                    (n_acc >= 16'hDC00) && (n_acc <= 16'hDFFF)) begin
                                    // Surrogate pair: join into one code point.
                                    v_pair  = 21'h10000 + {1'b0, n_hb, n_acc[9:0]};
                                    n_phase = PH_PLAIN;
                                    v_ob    = f_put_code(v_ob, v_pair);
                                end else begin
                                    if (n_phase == PH_HEX2) begin
                                        v_ob = f_put_high(v_ob, n_hb);
                                    end
                                    n_phase = PH_PLAIN;
                                    if ((n_acc >= 16'hD800) && (n_acc <= 16'hDBFF)) begin
                                        n_hb    = n_acc[9:0];
                                        n_phase = PH_WAIT_BS;
                                    end else begin
                                        v_ob = f_put_code(v_ob, {5'd0, n_acc});
                                    end
                                end
                            end
                        end
                    end
                    PH_WAIT_BS: begin
                        if (i_raw_byte == CH_BSLASH) begin
                            n_phase = PH_WAIT_U;
                        end else begin
                            v_ob    = f_put_high(v_ob, n_hb);
                            n_phase = PH_PLAIN;
                            v_done  = 1'b0;
                        end
                    end
                    PH_WAIT_U: begin
                        if (i_raw_byte == CH_LC_U) begin
                            n_phase = PH_HEX2;
                            n_acc   = '0;
                            n_seen  = '0;
                        end else begin
                            v_ob    = f_put_high(v_ob, n_hb);
                            n_phase = PH_ESC;
                            v_done  = 1'b0;
                        end
                    end
                    default: begin
                        n_phase = PH_PLAIN;
                        v_done  = 1'b0;
                    end
                endcase
            end
        end

        // End of body: flush whatever the escape machine still holds.
        if (i_is_last) begin
            case (n_phase)
                PH_ESC:     v_ob = f_put_byte(v_ob, CH_BSLASH);
                PH_HEX1:    v_ob = f_put_held(v_ob, n_seen, n_held);
                PH_WAIT_BS: v_ob = f_put_high(v_ob, n_hb);
                PH_WAIT_U: begin
                    v_ob = f_put_high(v_ob, n_hb);
                    v_ob = f_put_byte(v_ob, CH_BSLASH);
                end
                PH_HEX2: begin
                    v_ob = f_put_high(v_ob, n_hb);
                    v_ob = f_put_held(v_ob, n_seen, n_held);
                end
                default: ;
            endcase
            n_phase = PH_PLAIN;
            n_acc   = '0;
            n_seen  = '0;
            n_hb    = '0;
        end
    end

    assign o_burst.last  = i_is_last;
    assign o_burst.count = v_ob.cnt;
    assign o_burst.bytes = v_ob.data[jsu_pkg::BURST_MAX-1:0];
    assign o_push        = w_accept && ((v_ob.cnt != 3'd0) || i_is_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PLAIN;
            r_acc   <= '0;
            r_seen  <= '0;
            r_hb    <= '0;
        end else if (w_accept) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_seen  <= n_seen;
            r_hb    <= n_hb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_held <= n_held;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/jsu_queue.sv
// Short register queue of burst words between front and back.
// Depends on jsu_pkg for the burst type and the depth.
`timescale 1ns / 1ps
`default_nettype none

module jsu_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  jsu_pkg::t_burst  i_burst,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_head_valid,
    output jsu_pkg::t_burst  o_head
);

    jsu_pkg::t_burst                   r_mem [jsu_pkg::Q_DEPTH];
    logic [jsu_pkg::Q_AW-1:0]          r_wptr, r_rptr;
    logic [jsu_pkg::Q_CW-1:0]          r_count;

    assign o_full       = (r_count == jsu_pkg::Q_CW'(jsu_pkg::Q_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_burst;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/jsu_back.sv
// Back of the JSON string unescaper: walks the head burst one byte a cycle
// unless stalled. Holds the output register; depends on jsu_pkg for bursts.
`timescale 1ns / 1ps
`default_nettype none

module jsu_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_head_valid,
    input  jsu_pkg::t_burst  i_head,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [7:0]       o_out_byte,
    output logic             o_byte_valid,
    output logic             o_end_of_string
);

    logic [jsu_pkg::BURST_CW-1:0] r_idx;
    logic                         r_valid;
    logic [7:0]                   r_byte;
    logic                         r_bvalid;
    logic                         r_eos;
    logic                         w_load;
    logic                         w_marker;
    logic                         w_final;

    assign w_load   = i_head_valid && (!r_valid || i_ready);
    assign w_marker = (i_head.count == '0);
    assign w_final  = w_marker || ((r_idx + 1'b1) == i_head.count);
    assign o_pop    = w_load && w_final;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                r_idx   <= w_final ? '0 : r_idx + 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte   <= w_marker ? 8'h00 : i_head.bytes[r_idx];
            r_bvalid <= !w_marker;
            r_eos    <= i_head.last && w_final;
        end
    end

    assign o_valid         = r_valid;
    assign o_out_byte      = r_byte;
    assign o_byte_valid    = r_bvalid;
    assign o_end_of_string = r_eos;

endmodule

`default_nettype wire

>>> test/tb_json_string_unescape_utf8_top.sv
// Self-checking testbench for json_string_unescape_utf8_top: raw JSON string
// bodies in, unescaped UTF-8 words out, checked against an in-bench decoder.
// Depends only on the RTL of the block; reads and writes no files.
`timescale 1ns / 1ps

module tb_json_string_unescape_utf8_top;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 3;
    localparam int RANDOM_BYTES   = 340;
    // Longest correct quiet spell: a sender gap plus a stall run plus pipeline
    // latency. Take it many times over.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int MAX_REPORTS    = 40;

    // Characters that steer the escape scanner.
    localparam logic [7:0] CH_BSLASH = 8'h5C, CH_QUOTE = 8'h22, CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_UNKNOWN_ESC = "q", CH_FILLER = "A";
    localparam logic [7:0] ESC_B = "b", ESC_F = "f", ESC_N = "n", ESC_R = "r",
                           ESC_T = "t", ESC_U = "u";
    localparam logic [7:0] CTRL_BS = 8'h08, CTRL_FF = 8'h0C, CTRL_LF = 8'h0A,
                           CTRL_CR = 8'h0D, CTRL_TAB = 8'h09;
    localparam logic [7:0] DIGIT_0 = "0", LETTER_UPPER_A = "A", LETTER_LOWER_A = "a";

    // Code point ranges.
    localparam logic [15:0] HIGH_SURR_FIRST = 16'hD800, HIGH_SURR_LAST = 16'hDBFF;
    localparam logic [15:0] LOW_SURR_FIRST  = 16'hDC00, LOW_SURR_LAST  = 16'hDFFF;
    localparam logic [20:0] ONE_BYTE_MAX = 21'h7F, TWO_BYTE_MAX = 21'h7FF;
    localparam logic [20:0] THREE_BYTE_MAX = 21'hFFFF, SUPPLEMENTARY_BASE = 21'h10000;

    typedef enum logic [3:0] {
        SCAN_TEXT,          // plain bytes
        SCAN_ESCAPE,        // just saw a backslash
        SCAN_HEX,           // collecting the digits of a \u
        SCAN_HIGH_HELD,     // high surrogate held, want a backslash
        SCAN_HIGH_BSLASH,   // high surrogate held, want 'u'
        SCAN_LOW_HEX        // collecting the digits of the second \u
    } t_scan_phase;

    typedef struct packed {
        logic [7:0] raw;
        logic       last;
    } t_raw_word;

    typedef struct packed {
        logic [7:0] data;
        logic       data_valid;
        logic       eos;
    } t_utf8_word;

    // ------------------------------------------------------------------
    // Block ports
    // ------------------------------------------------------------------
    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_valid    = 1'b0;
    logic       o_ready;
    logic [7:0] i_raw_byte = 8'h00;
    logic       i_is_last  = 1'b0;
    logic       o_valid;
    logic       i_ready    = 1'b0;
    logic [7:0] o_out_byte;
    logic       o_byte_valid;
    logic       o_end_of_string;

    json_string_unescape_utf8_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_raw_byte     (i_raw_byte),
        .i_is_last      (i_is_last),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_out_byte     (o_out_byte),
        .o_byte_valid   (o_byte_valid),
        .o_end_of_string(o_end_of_string)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    t_raw_word  raw_pending_q[$];       // words still to be driven
    t_utf8_word utf8_expected_q[$];     // decoded words still owed by the block
    logic [7:0] step_bytes[$];          // bytes decoded from the current raw word
    logic [7:0] body_bytes[$];          // string body under construction
    logic [7:0] simple_escapes[8] = '{ESC_B, ESC_F, ESC_N, ESC_R, ESC_T,
                                      CH_QUOTE, CH_BSLASH, CH_SLASH};

    int   raw_total    = 0;
    int   raw_count    = 0;
    int   body_count   = 0;
    int   word_count   = 0;
    int   marker_count = 0;
    int   pair_count   = 0;
    int   error_count  = 0;
    int   idle_cycles  = 0;
    logic raw_taken    = 1'b0;

    // Decoder state, mirrored from the block's point of view.
    t_scan_phase phase = SCAN_TEXT;
    logic [15:0] hex_acc = '0;
    logic [2:0]  digits_seen = '0;
    logic [7:0]  held_digits[3];
    logic [9:0]  hi_bits = '0;

    // Append one byte to the decoded bytes of the current raw word.
    function automatic void add_step(input logic [7:0] b);
        step_bytes.insert(step_bytes.size(), b);
    endfunction

    // Append one byte to the body under construction.
    function automatic void add_body(input logic [7:0] b);
        body_bytes.insert(body_bytes.size(), b);
    endfunction

    // ------------------------------------------------------------------
    // UTF-8 unescape predictor
    // ------------------------------------------------------------------
    function automatic int hex_nibble_value(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c - "0");
        if (c >= "a" && c <= "f") return int'(c - "a") + 10;
        if (c >= "A" && c <= "F") return int'(c - "A") + 10;
        return -1;
    endfunction

    function automatic void emit_code(input logic [20:0] cp);
        if (cp <= ONE_BYTE_MAX) begin
            add_step(cp[7:0]);
        end else if (cp <= TWO_BYTE_MAX) begin
            add_step({3'b110, cp[10:6]});
            add_step({2'b10, cp[5:0]});
        end else if (cp <= THREE_BYTE_MAX) begin
            add_step({4'b1110, cp[15:12]});
            add_step({2'b10, cp[11:6]});
            add_step({2'b10, cp[5:0]});
        end else begin
            add_step({5'b11110, cp[20:18]});
            add_step({2'b10, cp[17:12]});
            add_step({2'b10, cp[11:6]});
            add_step({2'b10, cp[5:0]});
        end
    endfunction

    // Release the held high surrogate as a 3-byte sequence.
    function automatic void emit_high();
        emit_code(21'(HIGH_SURR_FIRST) + 21'(hi_bits));
    endfunction

    // Give back the digit characters of a \u that went wrong.
    function automatic void emit_held();
        for (int k = 0; k < int'(digits_seen); k++) add_step(held_digits[k]);
        digits_seen = '0;
    endfunction

    // Shift in one digit; true once the fourth digit is in.
    function automatic logic take_digit(input logic [7:0] c, input logic [3:0] nib);
        hex_acc = {hex_acc[11:0], nib};
        if (digits_seen < 3) begin
            held_digits[digits_seen] = c;
            digits_seen++;
            return 1'b0;
        end
        digits_seen = '0;
        return 1'b1;
    endfunction

    // A complete \u value with no partner yet: hold a high surrogate, emit the rest.
    function automatic void settle_code(input logic [15:0] cp);
        phase = SCAN_TEXT;
        if (cp >= HIGH_SURR_FIRST && cp <= HIGH_SURR_LAST) begin
            hi_bits = cp[9:0];
            phase   = SCAN_HIGH_HELD;
        end else begin
            emit_code(21'(cp));
        end
    endfunction

    task automatic decode_raw_word(input logic [7:0] c, input logic last);
        int         v;
        logic       again;
        t_utf8_word w;
        step_bytes.delete();
        again = 1'b1;
        // A byte that ends a pending escape is scanned again as text or as an escape.
        while (again) begin
            again = 1'b0;
            case (phase)
                SCAN_TEXT: begin
                    if (c == CH_BSLASH) phase = SCAN_ESCAPE;
                    else add_step(c);
                end
                SCAN_ESCAPE: begin
                    phase = SCAN_TEXT;
                    case (c)
                        ESC_B: add_step(CTRL_BS);
                        ESC_F: add_step(CTRL_FF);
                        ESC_N: add_step(CTRL_LF);
                        ESC_R: add_step(CTRL_CR);
                        ESC_T: add_step(CTRL_TAB);
                        ESC_U: begin
                            phase       = SCAN_HEX;
                            hex_acc     = '0;
                            digits_seen = '0;
                        end
                        default: add_step(c);
                    endcase
                end
                SCAN_HEX: begin
                    v = hex_nibble_value(c);
                    if (v < 0) begin
                        emit_held();
                        phase = SCAN_TEXT;
                        again = 1'b1;
                    end else if (take_digit(c, v[3:0])) begin
                        settle_code(hex_acc);
                    end
                end
                SCAN_HIGH_HELD: begin
                    if (c == CH_BSLASH) begin
                        phase = SCAN_HIGH_BSLASH;
                    end else begin
                        emit_high();
                        phase = SCAN_TEXT;
                        again = 1'b1;
                    end
                end
                SCAN_HIGH_BSLASH: begin
                    if (c == ESC_U) begin
                        phase       = SCAN_LOW_HEX;
                        hex_acc     = '0;
                        digits_seen = '0;
                    end else begin
                        emit_high();
                        phase = SCAN_ESCAPE;
                        again = 1'b1;
                    end
                end
                SCAN_LOW_HEX: begin
                    v = hex_nibble_value(c);
                    if (v < 0) begin
                        emit_high();
                        emit_held();
                        phase = SCAN_TEXT;
                        again = 1'b1;
                    end else if (take_digit(c, v[3:0])) begin
                        if (hex_acc >= LOW_SURR_FIRST && hex_acc <= LOW_SURR_LAST) begin
                            phase = SCAN_TEXT;
                            pair_count++;
                            emit_code(21'({hi_bits, hex_acc[9:0]}) + SUPPLEMENTARY_BASE);
                        end else begin
                            emit_high();
                            settle_code(hex_acc);
                        end
                    end
                end
                default: begin
                    phase = SCAN_TEXT;
                    again = 1'b1;
                end
            endcase
        end

        // End of body: flush whatever escape is still open, then clear.
        if (last) begin
            case (phase)
                SCAN_ESCAPE:      add_step(CH_BSLASH);
                SCAN_HEX:         emit_held();
                SCAN_HIGH_HELD:   emit_high();
                SCAN_HIGH_BSLASH: begin
                    emit_high();
                    add_step(CH_BSLASH);
                end
                SCAN_LOW_HEX: begin
                    emit_high();
                    emit_held();
                end
                default: ;
            endcase
            phase       = SCAN_TEXT;
            hex_acc     = '0;
            digits_seen = '0;
            hi_bits     = '0;
        end

        foreach (step_bytes[k]) begin
            w = '{data: step_bytes[k], data_valid: 1'b1,
                  eos: last && (k == step_bytes.size() - 1)};
            utf8_expected_q.insert(utf8_expected_q.size(), w);
        end
        // A silent last byte still closes the string with an empty marker.
        if (last && step_bytes.size() == 0) begin
            w = '{data: 8'h00, data_valid: 1'b0, eos: 1'b1};
            utf8_expected_q.insert(utf8_expected_q.size(), w);
            marker_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 10) return DIGIT_0 + {4'h0, nib};
        return ($urandom_range(0, 1) ? LETTER_UPPER_A : LETTER_LOWER_A) + {4'h0, nib} - 8'd10;
    endfunction

    function automatic logic [15:0] random_high();
        return HIGH_SURR_FIRST + 16'($urandom_range(0, 1023));
    endfunction

    function automatic logic [15:0] random_low();
        return LOW_SURR_FIRST + 16'($urandom_range(0, 1023));
    endfunction

    task automatic push_u_escape(input logic [15:0] value);
        add_body(CH_BSLASH);
        add_body(ESC_U);
        for (int n = 3; n >= 0; n--) add_body(hex_char(value[n*4 +: 4]));
    endtask

    // \u with good_digits hex digits and then a byte that is not a hex digit.
    task automatic push_bad_u(input int good_digits);
        logic [7:0] junk;
        add_body(CH_BSLASH);
        add_body(ESC_U);
        repeat (good_digits) add_body(hex_char(4'($urandom_range(0, 15))));
        junk = 8'($urandom_range(0, 255));
        while (hex_nibble_value(junk) >= 0) junk = 8'($urandom_range(0, 255));
        add_body(junk);
    endtask

    // Queue the built body, flagging its final byte.
    task automatic commit_body();
        t_raw_word w;
        foreach (body_bytes[k]) begin
            w = '{raw: body_bytes[k], last: (k == body_bytes.size() - 1)};
            raw_pending_q.insert(raw_pending_q.size(), w);
        end
        body_bytes.delete();
    endtask

    task automatic add_random_body();
        int unsigned tokens;
        int          keep;
        logic [7:0]  c;
        tokens = $urandom_range(1, 6);
        repeat (tokens) begin
            case ($urandom_range(0, 11))
                0, 1, 2, 3: begin
                    c = 8'($urandom_range(0, 255));
                    add_body(c == CH_BSLASH ? CH_SLASH : c);
                end
                4: begin
                    add_body(CH_BSLASH);
                    add_body(simple_escapes[$urandom_range(0, 7)]);
                end
                5: begin
                    add_body(CH_BSLASH);
                    add_body(8'($urandom_range(0, 255)));
                end
                6: begin
                    case ($urandom_range(0, 3))
                        0: push_u_escape(16'($urandom_range(0, 16'h7F)));
                        1: push_u_escape(16'($urandom_range(16'h80, 16'h7FF)));
                        2: push_u_escape(16'($urandom_range(16'h800, 16'hFFFF)));
                        default: push_u_escape(random_low());
                    endcase
                end
                7: push_u_escape(random_high());
                8, 9: begin
                    push_u_escape(random_high());
                    push_u_escape(random_low());
                end
                10: begin
                    // High surrogate followed by something that does not pair.
                    push_u_escape(random_high());
                    case ($urandom_range(0, 3))
                        0: push_u_escape($urandom_range(0, 1) ? random_high()
                                                              : 16'($urandom_range(0, 16'hD7FF)));
                        1: begin
                            c = 8'($urandom_range(0, 255));
                            add_body(CH_BSLASH);
                            add_body(c == ESC_U ? ESC_N : c);
                        end
                        2: push_bad_u($urandom_range(0, 3));
                        default: add_body(CH_FILLER + 8'($urandom_range(0, 25)));
                    endcase
                end
                default: push_bad_u($urandom_range(0, 3));
            endcase
        end
        // Cut some bodies short, so that some end in the middle of an escape.
        if ($urandom_range(0, 3) == 0 && body_bytes.size() > 1) begin
            keep = $urandom_range(1, body_bytes.size());
            while (body_bytes.size() > keep) void'(body_bytes.pop_back());
        end
        commit_body();
    endtask

    // ------------------------------------------------------------------
    // Mismatch reporting
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("ERROR t=%0t word %0d: %s", $time, word_count, msg);
    endtask

    // ------------------------------------------------------------------
    // Raw byte driver: bursts of random length separated by random gaps.
    // Drive on the falling edge; hold the word until the monitor saw it taken.
    // ------------------------------------------------------------------
    int burst_left = 1;
    int gap_left   = 0;

    always @(negedge i_clk) begin : raw_driver
        logic      next_valid;
        t_raw_word next_word;
        if (i_rst_n) begin
            next_valid = i_valid;
            next_word  = '{raw: i_raw_byte, last: i_is_last};
            if (!i_valid || raw_taken) begin
                next_valid = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (raw_pending_q.size() > 0) begin
                    next_word  = raw_pending_q.pop_front();
                    next_valid = 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        // Start the next burst; a quarter of them run back to back.
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
            end
            i_valid    <= next_valid;
            i_raw_byte <= next_word.raw;
            i_is_last  <= next_word.last;
        end
    end

    // ------------------------------------------------------------------
    // Decoded word sink: rotate a stall pattern, swap it when its random age runs out.
    // ------------------------------------------------------------------
    logic [15:0] stall_pattern = '1;
    int          pattern_age   = 0;

    always @(negedge i_clk) begin : word_sink
        if (i_rst_n) begin
            if (pattern_age == 0) begin
                case ($urandom_range(0, 4))
                    0, 1: stall_pattern = '1;                         // never stall
                    2:    stall_pattern = 16'($urandom) | 16'h0001;   // random stalls
                    3:    stall_pattern = 16'hAAAA;                   // alternating stalls
                    default: stall_pattern = 16'h0101;                // heavy back-pressure
                endcase
                pattern_age = $urandom_range(20, 80);
            end
            pattern_age--;
            i_ready       <= stall_pattern[0];
            stall_pattern  = {stall_pattern[0], stall_pattern[15:1]};
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on every accepted raw word, check every accepted output word.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : word_monitor
        t_utf8_word got;
        t_utf8_word want;
        logic       out_taken;
        raw_taken = 1'b0;
        if (i_rst_n) begin
            raw_taken = i_valid && o_ready;
            out_taken = o_valid && i_ready;
            if (raw_taken) begin
                decode_raw_word(i_raw_byte, i_is_last);
                raw_count++;
                if (i_is_last) body_count++;
            end
            if (out_taken) begin
                got = '{data: o_out_byte, data_valid: o_byte_valid, eos: o_end_of_string};
                word_count++;
                if (utf8_expected_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected word byte=%02h valid=%b end=%b",
                                              got.data, got.data_valid, got.eos));
                end else begin
                    want = utf8_expected_q.pop_front();
                    if (got !== want)
                        report_mismatch($sformatf(
                            "byte=%02h valid=%b end=%b, want byte=%02h valid=%b end=%b",
                            got.data, got.data_valid, got.eos,
                            want.data, want.data_valid, want.eos));
                end
            end
            if (raw_taken || out_taken) idle_cycles = 0;
            else idle_cycles++;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if nothing moves for too long.
    // ------------------------------------------------------------------
    initial begin : watchdog
        while (idle_cycles < WATCHDOG_LIMIT) @(negedge i_clk);
        $display("ERROR: no word accepted for %0d cycles, %0d decoded words still owed",
                 WATCHDOG_LIMIT, utf8_expected_q.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin : stimulus
        // Control escapes, backslash and an unknown escape, framed by the
        // extreme byte values.
        body_bytes = '{8'h00, CH_BSLASH, ESC_N, CH_BSLASH, ESC_T, CH_BSLASH, ESC_B,
                       CH_BSLASH, ESC_F, CH_BSLASH, ESC_R, CH_BSLASH, CH_BSLASH,
                       CH_BSLASH, CH_UNKNOWN_ESC, 8'hFF};
        commit_body();
        // Body ends inside a \u after two digits: digits come back literally.
        body_bytes = '{CH_BSLASH, ESC_U, hex_char(4'h1), hex_char(4'h2)};
        commit_body();
        // Trailing lone backslash.
        body_bytes = '{CH_BSLASH};
        commit_body();
        // Body ends right after \u: nothing decoded, so an empty marker closes it.
        body_bytes = '{CH_BSLASH, ESC_U};
        commit_body();

        // Random bodies of plain bytes, escapes, \u values, surrogates and bad \u runs.
        while (raw_pending_q.size() < 23 + RANDOM_BYTES) add_random_body();
        raw_total = raw_pending_q.size();

        // Hold reset, then release it on a falling edge.
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: all raw words in, all decoded words out, then a quiet tail.
        while (raw_count < raw_total) @(negedge i_clk);
        while (utf8_expected_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Run covered %0d raw bytes in %0d string bodies and checked %0d output words,",
                 raw_count, body_count, word_count);
        $display("with %0d surrogate pairs, %0d empty end markers and %0d mismatches.",
                 pair_count, marker_count, error_count);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/core/jsu_pkg.sv
rtl/core/jsu_front.sv
rtl/core/jsu_queue.sv
rtl/core/jsu_back.sv
rtl/core/json_string_unescape_utf8_top.sv
test/tb_json_string_unescape_utf8_top.sv
